FILE: rtl/core/tahd_pkg.sv
package tahd_pkg;

  // Axis count and field widths
  localparam int Axes        = 3;
  localparam int SampleWidth = 16;
  localparam int MagWidth    = SampleWidth + 1;
  localparam int TimeWidth   = 32;
  localparam int CfgWidth    = 16;
  localparam int CfgIdxWidth = 8;

  // Axis positions
  localparam int AxisX = 0;
  localparam int AxisY = 1;
  localparam int AxisZ = 2;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegHighThreshold = 8'd0;
  localparam logic [CfgIdxWidth-1:0] RegLowThreshold  = 8'd1;
  localparam logic [CfgIdxWidth-1:0] RegZOffset       = 8'd2;
  localparam logic [CfgIdxWidth-1:0] RegHoldoffMs     = 8'd3;

  // Register reset values
  localparam logic [CfgWidth-1:0] HighThresholdReset = 16'd14000;
  localparam logic [CfgWidth-1:0] LowThresholdReset  = 16'd8000;
  localparam logic [CfgWidth-1:0] ZOffsetReset       = 16'd16400;
  localparam logic [CfgWidth-1:0] HoldoffMsReset     = 16'd150;

  typedef logic signed [MagWidth-1:0] axis_val_t;
  typedef logic [MagWidth-1:0]        axis_mag_t;
  typedef logic [TimeWidth-1:0]       stamp_t;

  // Absolute value; the input never reaches the most negative code
  function automatic axis_mag_t axis_abs(input axis_val_t v);
    axis_mag_t r;
    r = v[MagWidth-1] ? axis_mag_t'(-v) : axis_mag_t'(v);
    return r;
  endfunction

endpackage

FILE: rtl/core/three_axis_hit_detector.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+------------------------------------
// in       | sink      | in_valid / in_stall     | accel_x, accel_y, accel_z, time_ms
// out      | source    | out_valid / out_stall   | hit_x, hit_y, hit_z
// cfg      | sink      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One request per clock is taken while in_stall is low; an accepted request passes
// through the input register, then the result register, to the output.
// All per-axis compares and the wrapped time subtraction sit between those two registers.
// rst is synchronous, active high; it restores the register defaults, arms all
// axes and clears the last-hit times.
// out_stall holds a valid result register; a full input register then holds too and
// in_stall rises only while the input register is full and cannot advance.
// cfg_ready is always high.
module three_axis_hit_detector
  import tahd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SampleWidth-1:0] accel_x,
  input  logic signed [SampleWidth-1:0] accel_y,
  input  logic signed [SampleWidth-1:0] accel_z,
  input  logic [TimeWidth-1:0]          time_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit_x,
  output logic                          hit_y,
  output logic                          hit_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CfgIdxWidth-1:0]        cfg_index,
  input  logic [CfgWidth-1:0]           cfg_data
);

  // Configuration registers
  logic [CfgWidth-1:0]        high_threshold;
  logic [CfgWidth-1:0]        low_threshold;
  logic signed [CfgWidth-1:0] z_offset;
  logic [CfgWidth-1:0]        holdoff_ms;

  // Input register
  logic                          s1_valid;
  logic signed [SampleWidth-1:0] s1_x;
  logic signed [SampleWidth-1:0] s1_y;
  logic signed [SampleWidth-1:0] s1_z;
  stamp_t                        s1_time;

  // Per-axis state
  logic [Axes-1:0] latched;
  logic [Axes-1:0] latched_next;
  stamp_t          last_hit_time [Axes];

  // Datapath
  axis_val_t       sample [Axes];
  axis_mag_t       mag    [Axes];
  stamp_t          elapsed [Axes];
  logic [Axes-1:0] fire;
  logic [Axes-1:0] hit;

  logic out_free;
  logic s1_move;
  logic in_take;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign s1_move   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_take   = in_valid && !in_stall;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold <= HighThresholdReset;
      low_threshold  <= LowThresholdReset;
      z_offset       <= ZOffsetReset;
      holdoff_ms     <= HoldoffMsReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegHighThreshold: high_threshold <= cfg_data;
        RegLowThreshold:  low_threshold  <= cfg_data;
        RegZOffset:       z_offset       <= cfg_data;
        RegHoldoffMs:     holdoff_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the request into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_x    <= accel_x;
      s1_y    <= accel_y;
      s1_z    <= accel_z;
      s1_time <= time_ms;
    end
  end

  // Remove gravity from Z, then test fire and re-arm per axis
  always_comb begin
    sample[AxisX] = axis_val_t'(s1_x);
    sample[AxisY] = axis_val_t'(s1_y);
    sample[AxisZ] = axis_val_t'(s1_z) - axis_val_t'(z_offset);
    for (int i = 0; i < Axes; i++) begin
      mag[i]     = axis_abs(sample[i]);
      elapsed[i] = s1_time - last_hit_time[i];
      fire[i]    = (mag[i] > axis_mag_t'(high_threshold)) && !latched[i] &&
                   (elapsed[i] > stamp_t'(holdoff_ms));
      latched_next[i] = (latched[i] || fire[i]) &&
                        !(mag[i] < axis_mag_t'(low_threshold));
    end
  end

  // Advance axis state when the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      latched <= '0;
      for (int i = 0; i < Axes; i++) begin
        last_hit_time[i] <= '0;
      end
    end else if (s1_move) begin
      latched <= latched_next;
      for (int i = 0; i < Axes; i++) begin
        if (fire[i]) begin
          last_hit_time[i] <= s1_time;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (s1_move) begin
      hit <= fire;
    end
  end

  assign hit_x = hit[AxisX];
  assign hit_y = hit[AxisY];
  assign hit_z = hit[AxisZ];

  // A fired X axis records the request time
  a_fire_records_time: assert property (@(posedge clk) disable iff (rst)
    s1_move && fire[AxisX] |=> last_hit_time[AxisX] == $past(s1_time))
    else $error("X hit did not record its time");

  // The latched state and the Z last-hit time hold while no request advances
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !s1_move |=> $stable(latched) && $stable(last_hit_time[AxisZ]))
    else $error("axis state changed without an advancing request");

  // An advancing request always lands in the result register
  a_move_loads_out: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid && hit == $past(fire))
    else $error("advancing request lost");

  // A fired Y axis cannot fire again while it stays latched
  a_no_double_fire: assert property (@(posedge clk) disable iff (rst)
    s1_move && fire[AxisY] |=> !fire[AxisY] || !s1_valid || latched[AxisY] == 1'b0)
    else $error("Y fired while latched");

endmodule
